/* design/pcd_pkg.sv */
// Shared types and codes for the page cache directory.
package pcd_pkg;

    localparam int SLOT_W = 6;
    localparam int RANK_W = 6;
    localparam int TAG_W  = 32;
    localparam int CMD_W  = 3;
    localparam int ACT_W  = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOUCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

    // Result action codes.
    localparam logic [ACT_W-1:0] ACT_HIT       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_NOT_FOUND = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FETCH     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READAHEAD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WRITEBACK = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BYPASS    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_FETCH_ERR = 3'd6;
    localparam logic [ACT_W-1:0] ACT_DONE      = 3'd7;

    // Configuration register indexes.
    localparam logic REG_REPLACE_MODE  = 1'b0;
    localparam logic REG_BACKING_COUNT = 1'b1;

    // Update applied to every cell of the row at one clock edge.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_MOVE_FRONT,
        OP_INSERT,
        OP_CLEAR
    } pcd_op_kind_t;

    typedef struct packed {
        pcd_op_kind_t      kind;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
        logic              set_dirty;
    } pcd_op_t;

    // Question asked of every cell in the current cycle.
    typedef enum logic [1:0] {
        Q_MATCH,
        Q_TAIL,
        Q_FLUSH
    } pcd_query_kind_t;

    typedef struct packed {
        pcd_query_kind_t   kind;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } pcd_query_t;

    // What one cell reports.
    typedef struct packed {
        logic              sel;
        logic              free;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
        logic              dirty;
    } pcd_stat_t;

    // Answer gathered from the whole row.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
        logic              dirty;
    } pcd_rd_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TAG_W-1:0]  page;
        logic [SLOT_W-1:0] slot;
    } pcd_result_t;

endpackage

/* design/pcd_cell.sv */
// One cache slot: tag, valid, dirty and recency rank with local compare and update.
module pcd_cell
    import pcd_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  pcd_query_t query,
    input  pcd_op_t    op,
    output pcd_stat_t  stat
);

    logic              valid_reg, valid_next;
    logic              dirty_reg, dirty_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              me;

    // Report this slot and answer the current question.
    always_comb begin
        stat.free  = !valid_reg;
        stat.tag   = tag_reg;
        stat.rank  = rank_reg;
        stat.dirty = dirty_reg;
        case (query.kind)
            Q_MATCH: stat.sel = valid_reg && (tag_reg == query.tag);
            Q_TAIL:  stat.sel = valid_reg && (rank_reg == query.rank);
            Q_FLUSH: stat.sel = valid_reg && dirty_reg && (rank_reg == query.rank);
            default: stat.sel = 1'b0;
        endcase
    end

    // Apply the broadcast update.
    always_comb begin
        me         = (op.slot == SLOT_W'(CELL_IDX));
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        tag_next   = tag_reg;
        rank_next  = rank_reg;
        case (op.kind)
            OP_MOVE_FRONT: begin
                if (me) begin
                    rank_next  = '0;
                    dirty_next = dirty_reg | op.set_dirty;
                end else if (valid_reg && (rank_reg < op.rank)) begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            OP_INSERT: begin
                if (me) begin
                    valid_next = 1'b1;
                    tag_next   = op.tag;
                    dirty_next = op.set_dirty;
                    rank_next  = '0;
                end else if (valid_reg) begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            OP_CLEAR: begin
                valid_next = 1'b0;
                dirty_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Control bits are reset; tag and rank are only read while valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg  <= tag_next;
        rank_reg <= rank_next;
    end

endmodule

/* design/pcd_ctrl.sv */
// Command sequencer: decides hits and misses, drives the cell row and orders results.
module pcd_ctrl
    import pcd_pkg::*;
#(
    parameter int CACHE_PAGES     = 32,
    parameter int READAHEAD_PAGES = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  in_command,
    input  logic [TAG_W-1:0]  in_page,
    input  logic              in_full,
    input  logic [3:0]        in_ok,
    input  logic              replace_mode,
    input  logic [30:0]       backing_count,
    input  pcd_rd_t           rd,
    input  logic              free_any,
    input  logic [SLOT_W-1:0] free_slot,
    input  logic              out_free,
    output pcd_query_t        query,
    output pcd_op_t           op,
    output logic              push,
    output pcd_result_t       push_res,
    output logic              push_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_WB,
        ST_RA,
        ST_FLUSH,
        ST_FLUSH_DONE,
        ST_FINISH
    } state_t;

    localparam logic [RANK_W-1:0] TAIL_RANK = RANK_W'(CACHE_PAGES - 1);
    localparam logic [2:0]        RA_LAST   = 3'(READAHEAD_PAGES);

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              full_reg, full_next;
    logic [3:0]        ok_reg, ok_next;
    pcd_query_t        query_reg, query_next;
    logic [2:0]        ra_reg, ra_next;
    logic [ACT_W-1:0]  lact_reg, lact_next;
    logic [TAG_W-1:0]  ltag_reg, ltag_next;
    logic [TAG_W-1:0]  vtag_reg, vtag_next;
    logic [SLOT_W-1:0] vslot_reg, vslot_next;
    logic              pend_valid_reg, pend_valid_next;
    pcd_result_t       pend_reg, pend_next;

    logic              emit_ok, do_emit, goto_ra, after_load, nonpos, ra_cond;
    pcd_result_t       emit_res;
    logic [TAG_W-1:0]  ra_page;
    logic [SLOT_W-1:0] load_slot;

    assign in_ready = (state_reg == ST_IDLE);
    assign query    = query_reg;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign nonpos   = tag_reg[TAG_W-1] || (tag_reg == '0);
    assign ra_page  = tag_reg + TAG_W'(ra_reg);
    assign ra_cond  = (ra_page < {1'b0, backing_count}) && !rd.found && ok_reg[ra_reg[1:0]];
    assign load_slot = free_any ? free_slot : rd.slot;

    // Next-state logic. A result is held in a pending register until the next
    // one is known, so the final result of a command can carry the last flag.
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        tag_next        = tag_reg;
        full_next       = full_reg;
        ok_next         = ok_reg;
        query_next      = query_reg;
        ra_next         = ra_reg;
        lact_next       = lact_reg;
        ltag_next       = ltag_reg;
        vtag_next       = vtag_reg;
        vslot_next      = vslot_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        op              = '0;
        op.kind         = OP_NONE;
        do_emit         = 1'b0;
        emit_res        = '0;
        goto_ra         = 1'b0;
        after_load      = 1'b0;
        push            = 1'b0;
        push_res        = pend_reg;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next        = in_command;
                    tag_next        = in_page;
                    full_next       = in_full;
                    ok_next         = in_ok;
                    query_next.kind = Q_MATCH;
                    query_next.tag  = in_page;
                    query_next.rank = '0;
                    state_next      = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (emit_ok) begin
                    if (cmd_reg == CMD_READ || cmd_reg == CMD_WRITE) begin
                        if (nonpos) begin
                            do_emit    = 1'b1;
                            emit_res   = '{ACT_BYPASS, tag_reg, '0};
                            state_next = ST_FINISH;
                        end else if (rd.found) begin
                            do_emit       = 1'b1;
                            emit_res      = '{ACT_HIT, tag_reg, rd.slot};
                            op.kind       = OP_MOVE_FRONT;
                            op.slot       = rd.slot;
                            op.rank       = rd.rank;
                            op.set_dirty  = (cmd_reg == CMD_WRITE);
                            state_next    = ST_FINISH;
                        end else if (cmd_reg == CMD_WRITE && full_reg) begin
                            do_emit    = 1'b1;
                            emit_res   = '{ACT_BYPASS, tag_reg, '0};
                            state_next = ST_FINISH;
                        end else if (!ok_reg[0]) begin
                            do_emit    = 1'b1;
                            emit_res   = '{ACT_FETCH_ERR, tag_reg, '0};
                            state_next = ST_FINISH;
                        end else begin
                            lact_next       = ACT_FETCH;
                            ltag_next       = tag_reg;
                            query_next.kind = Q_TAIL;
                            query_next.rank = TAIL_RANK;
                            state_next      = ST_LOAD;
                        end
                    end else if (cmd_reg == CMD_GET || cmd_reg == CMD_TOUCH) begin
                        do_emit    = 1'b1;
                        state_next = ST_FINISH;
                        if (!nonpos && rd.found) begin
                            emit_res = '{ACT_HIT, tag_reg, rd.slot};
                            if (cmd_reg == CMD_TOUCH || !replace_mode) begin
                                op.kind = OP_MOVE_FRONT;
                                op.slot = rd.slot;
                                op.rank = rd.rank;
                            end
                        end else begin
                            emit_res = '{ACT_NOT_FOUND, tag_reg, '0};
                        end
                    end else if (cmd_reg == CMD_FLUSH) begin
                        query_next.kind = Q_FLUSH;
                        query_next.rank = '0;
                        state_next      = ST_FLUSH;
                    end else begin
                        do_emit    = 1'b1;
                        emit_res   = '{ACT_DONE, '0, '0};
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_LOAD: begin
                // Free slot if any, otherwise the tail slot is replaced.
                if (emit_ok) begin
                    do_emit      = 1'b1;
                    emit_res     = '{lact_reg, ltag_reg, load_slot};
                    op.kind      = OP_INSERT;
                    op.slot      = load_slot;
                    op.tag       = ltag_reg;
                    op.set_dirty = (cmd_reg == CMD_WRITE);
                    if (!free_any && rd.dirty) begin
                        vtag_next  = rd.tag;
                        vslot_next = rd.slot;
                        state_next = ST_WB;
                    end else begin
                        after_load = 1'b1;
                    end
                end
            end
            ST_WB: begin
                if (emit_ok) begin
                    do_emit    = 1'b1;
                    emit_res   = '{ACT_WRITEBACK, vtag_reg, vslot_reg};
                    after_load = 1'b1;
                end
            end
            ST_RA: begin
                if (ra_cond) begin
                    lact_next       = ACT_READAHEAD;
                    ltag_next       = ra_page;
                    query_next.kind = Q_TAIL;
                    query_next.rank = TAIL_RANK;
                    state_next      = ST_LOAD;
                end else begin
                    ra_next = ra_reg + 1'b1;
                    goto_ra = 1'b1;
                end
            end
            ST_FLUSH: begin
                // One rank per cycle, front to tail, holding on a dirty rank while the output is busy.
                if (!rd.found || emit_ok) begin
                    if (rd.found) begin
                        do_emit  = 1'b1;
                        emit_res = '{ACT_WRITEBACK, rd.tag, rd.slot};
                    end
                    if (query_reg.rank == TAIL_RANK) begin
                        state_next = ST_FLUSH_DONE;
                    end else begin
                        query_next.rank = query_reg.rank + 1'b1;
                    end
                end
            end
            ST_FLUSH_DONE: begin
                if (emit_ok) begin
                    do_emit    = 1'b1;
                    emit_res   = '{ACT_DONE, '0, '0};
                    op.kind    = OP_CLEAR;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Where to go once a page has been loaded.
        if (after_load) begin
            if (lact_reg == ACT_READAHEAD) begin
                ra_next = ra_reg + 1'b1;
                goto_ra = 1'b1;
            end else if (cmd_reg == CMD_READ) begin
                ra_next = 3'd1;
                goto_ra = 1'b1;
            end else begin
                state_next = ST_FINISH;
            end
        end

        // Step to the next readahead candidate or finish.
        if (goto_ra) begin
            if (ra_next > RA_LAST) begin
                state_next = ST_FINISH;
            end else begin
                query_next.kind = Q_MATCH;
                query_next.tag  = tag_reg + TAG_W'(ra_next);
                state_next      = ST_RA;
            end
        end

        // A new result pushes the previous one out.
        if (do_emit) begin
            push            = pend_valid_reg;
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
        cmd_reg   <= cmd_next;
        tag_reg   <= tag_next;
        full_reg  <= full_next;
        ok_reg    <= ok_next;
        query_reg <= query_next;
        ra_reg    <= ra_next;
        lact_reg  <= lact_next;
        ltag_reg  <= ltag_next;
        vtag_reg  <= vtag_next;
        vslot_reg <= vslot_next;
        pend_reg  <= pend_next;
    end

endmodule

/* design/page_cache_lru_fifo_directory.sv */
// Page cache directory top level: configuration, slot row, answer gathering and output stage.
//
// Fully associative write-back page cache directory over CACHE_PAGES slots, each slot a
// cell in a row that compares its tag and updates its recency rank locally. One command
// is handled at a time. A hit or any single-result command passes through accept, lookup
// over the row and release of the last result; a miss adds a load step per page loaded
// and a write-back step per dirty victim, and each readahead candidate adds a lookup.
// A flush walks the row one rank per cycle, holding while a write-back cannot be emitted.
// Commands are serialized by the single shared lookup and update pass over the cell row.
// Results leave through a registered output stage at up to one per cycle.
module page_cache_lru_fifo_directory
    import pcd_pkg::*;
#(
    parameter int CACHE_PAGES     = 32,
    parameter int READAHEAD_PAGES = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // command[2:0], page_number[34:3], full_page_write[35],
                                  // fetch_ok_mask[39:36]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // action[2:0], page_of_action[34:3], slot_index[40:35],
                                  // zero fill[47:41]
    output logic        m_tlast
);

    logic              mode_reg;
    logic [30:0]       count_reg;
    pcd_query_t        query;
    pcd_op_t           op;
    pcd_stat_t         stat [CACHE_PAGES];
    logic [CACHE_PAGES-1:0] sel_vec;
    pcd_rd_t           rd;
    logic              free_any;
    logic [SLOT_W-1:0] free_slot;
    logic              out_free, push, push_last;
    pcd_result_t       push_res;
    logic              m_valid_reg, m_valid_next;
    pcd_result_t       m_res_reg, m_res_next;
    logic              m_last_reg, m_last_next;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index[0])
                REG_REPLACE_MODE:  mode_reg  <= cfg_data[0];
                REG_BACKING_COUNT: count_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Row of slot cells.
    for (genvar g = 0; g < CACHE_PAGES; g++) begin : g_cell
        pcd_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .query  (query),
            .op     (op),
            .stat   (stat[g])
        );
        assign sel_vec[g] = stat[g].sel;
    end

    // Gather the selected cell; at most one answers a question.
    always_comb begin
        rd = '0;
        for (int k = 0; k < CACHE_PAGES; k++) begin
            if (stat[k].sel) begin
                rd.found = 1'b1;
                rd.slot  = rd.slot | SLOT_W'(k);
                rd.tag   = rd.tag | stat[k].tag;
                rd.rank  = rd.rank | stat[k].rank;
                rd.dirty = rd.dirty | stat[k].dirty;
            end
        end
    end

    // Lowest free slot.
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int k = CACHE_PAGES - 1; k >= 0; k--) begin
            if (stat[k].free) begin
                free_any  = 1'b1;
                free_slot = SLOT_W'(k);
            end
        end
    end

    pcd_ctrl #(
        .CACHE_PAGES    (CACHE_PAGES),
        .READAHEAD_PAGES(READAHEAD_PAGES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_command   (s_tdata[2:0]),
        .in_page      (s_tdata[34:3]),
        .in_full      (s_tdata[35]),
        .in_ok        (s_tdata[39:36]),
        .replace_mode (mode_reg),
        .backing_count(count_reg),
        .rd           (rd),
        .free_any     (free_any),
        .free_slot    (free_slot),
        .out_free     (out_free),
        .query        (query),
        .op           (op),
        .push         (push),
        .push_res     (push_res),
        .push_last    (push_last)
    );

    // Output register stage.
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_last_next  = m_last_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_res_next   = push_res;
            m_last_next  = push_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_res_reg.slot, m_res_reg.page, m_res_reg.action};
    assign m_tlast  = m_last_reg;

    // Tags and ranks of valid slots are distinct, so no question selects two cells.
    a_sel_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_vec))
        else $error("more than one cell answered the lookup");

    // With every slot taken, the tail slot must exist.
    a_tail_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (query.kind == Q_TAIL && !free_any) |-> rd.found)
        else $error("full cache without a tail slot");

    // A push never overwrites a result still waiting downstream.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !push)
        else $error("result pushed over a stalled output");

    // One command at a time.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while busy");

endmodule

/* tb/pcd_action_checker.sv */
// Result checker for the page cache directory: tracks the directory state and compares results.
module pcd_action_checker
    import pcd_pkg::*;
#(
    parameter int CACHE_PAGES     = 32,
    parameter int READAHEAD_PAGES = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,  // command[2:0], page_number[34:3], full_page_write[35],
                                  // fetch_ok_mask[39:36]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,  // action[2:0], page_of_action[34:3], slot_index[40:35],
                                  // zero fill[47:41]
    input  logic        m_tlast,
    output int          fail_count,
    output int          open_count
);

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TAG_W-1:0]  page;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } dir_action_t;

    // Directory state as the block should hold it.
    logic             valid_q [CACHE_PAGES];
    logic [TAG_W-1:0] tag_q   [CACHE_PAGES];
    logic             dirty_q [CACHE_PAGES];
    int unsigned      rank_q  [CACHE_PAGES];
    logic             fifo_gets;
    logic [30:0]      store_pages;

    dir_action_t      step_actions[$];
    dir_action_t      expected_actions[$];
    int               fails = 0;

    function automatic void post_action(input logic [ACT_W-1:0] act,
                                        input logic [TAG_W-1:0] page, input int slot);
        step_actions.push_back({act, page, SLOT_W'(slot), 1'b0});
    endfunction

    function automatic int lookup_slot(input logic [TAG_W-1:0] tag);
        for (int s = 0; s < CACHE_PAGES; s++)
            if (valid_q[s] && tag_q[s] == tag) return s;
        return -1;
    endfunction

    // Move a slot to the front; slots that were ahead of it age by one.
    function automatic void promote_slot(input int s);
        for (int k = 0; k < CACHE_PAGES; k++)
            if (valid_q[k] && k != s && rank_q[k] < rank_q[s]) rank_q[k]++;
        rank_q[s] = 0;
    endfunction

    // Load a page into the lowest free slot, or into the tail slot after evicting it.
    function automatic int install_page(input logic [TAG_W-1:0] tag,
                                        input logic [ACT_W-1:0] act);
        int               s;
        int               victim;
        logic [TAG_W-1:0] victim_tag;
        logic             victim_dirty;
        s = -1;
        victim = -1;
        victim_tag = '0;
        victim_dirty = 1'b0;
        for (int k = 0; k < CACHE_PAGES; k++)
            if (s < 0 && !valid_q[k]) s = k;
        if (s < 0) begin
            victim = 0;
            for (int k = 1; k < CACHE_PAGES; k++)
                if (rank_q[k] > rank_q[victim]) victim = k;
            victim_tag = tag_q[victim];
            victim_dirty = dirty_q[victim];
            valid_q[victim] = 1'b0;
            dirty_q[victim] = 1'b0;
            s = victim;
        end
        post_action(act, tag, s);
        if (victim_dirty) post_action(ACT_WRITEBACK, victim_tag, victim);
        for (int k = 0; k < CACHE_PAGES; k++)
            if (valid_q[k]) rank_q[k]++;
        valid_q[s] = 1'b1;
        tag_q[s] = tag;
        dirty_q[s] = 1'b0;
        rank_q[s] = 0;
        return s;
    endfunction

    // Work out every result one command causes and queue them in order.
    function automatic void predict_directory_step(input logic [CMD_W-1:0] cmd,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic full, input logic [3:0] ok);
        longint           page_val;
        longint           p;
        logic [TAG_W-1:0] ptag;
        int               s;
        dir_action_t      r;
        step_actions.delete();
        page_val = $signed(tag);
        case (cmd)
            CMD_READ, CMD_WRITE: begin
                if (page_val <= 0) begin
                    post_action(ACT_BYPASS, tag, 0);
                end else begin
                    s = lookup_slot(tag);
                    if (s >= 0) begin
                        post_action(ACT_HIT, tag, s);
                        if (cmd == CMD_WRITE) dirty_q[s] = 1'b1;
                        promote_slot(s);
                    end else if (cmd == CMD_WRITE && full) begin
                        post_action(ACT_BYPASS, tag, 0);
                    end else if (!ok[0]) begin
                        post_action(ACT_FETCH_ERR, tag, 0);
                    end else begin
                        s = install_page(tag, ACT_FETCH);
                        if (cmd == CMD_WRITE) begin
                            dirty_q[s] = 1'b1;
                        end else begin
                            // Readahead skips pages beyond the store, cached or failed.
                            for (int i = 1; i <= READAHEAD_PAGES; i++) begin
                                p = page_val + i;
                                ptag = p[TAG_W-1:0];
                                if (p < longint'(store_pages) && lookup_slot(ptag) < 0
                                    && ok[i])
                                    void'(install_page(ptag, ACT_READAHEAD));
                            end
                        end
                    end
                end
            end
            CMD_GET, CMD_TOUCH: begin
                s = (page_val > 0) ? lookup_slot(tag) : -1;
                if (s < 0) begin
                    post_action(ACT_NOT_FOUND, tag, 0);
                end else begin
                    post_action(ACT_HIT, tag, s);
                    if (cmd == CMD_TOUCH || !fifo_gets) promote_slot(s);
                end
            end
            CMD_FLUSH: begin
                // Dirty pages are written back from the front to the tail.
                for (int unsigned rk = 0; rk < CACHE_PAGES; rk++)
                    for (int k = 0; k < CACHE_PAGES; k++)
                        if (valid_q[k] && rank_q[k] == rk && dirty_q[k])
                            post_action(ACT_WRITEBACK, tag_q[k], k);
                for (int k = 0; k < CACHE_PAGES; k++) begin
                    valid_q[k] = 1'b0;
                    dirty_q[k] = 1'b0;
                end
                post_action(ACT_DONE, '0, 0);
            end
            default: begin
                post_action(ACT_DONE, '0, 0);
            end
        endcase
        for (int j = 0; j < step_actions.size(); j++) begin
            r = step_actions[j];
            r.last = (j == step_actions.size() - 1);
            expected_actions.push_back(r);
        end
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge aclk) begin : watch
        dir_action_t seen;
        dir_action_t want;
        if (!aresetn) begin
            for (int k = 0; k < CACHE_PAGES; k++) begin
                valid_q[k] = 1'b0;
                dirty_q[k] = 1'b0;
                tag_q[k] = '0;
                rank_q[k] = 0;
            end
            fifo_gets = 1'b0;
            store_pages = '0;
            expected_actions.delete();
        end else begin
            // Result transaction: compare with the oldest expectation.
            if (m_tvalid && m_tready) begin
                seen = {m_tdata[2:0], m_tdata[34:3], m_tdata[40:35], m_tlast};
                if (expected_actions.size() == 0) begin
                    fails++;
                    $display({"%0t: unexpected result: expected none, actual action %0d ",
                              "page %h slot %0d last %0b"},
                             $time, seen.action, seen.page, seen.slot, seen.last);
                end else begin
                    want = expected_actions.pop_front();
                    if (seen !== want) begin
                        fails++;
                        $display({"%0t: result mismatch: expected action %0d page %h ",
                                  "slot %0d last %0b, actual action %0d page %h ",
                                  "slot %0d last %0b"},
                                 $time, want.action, want.page, want.slot, want.last,
                                 seen.action, seen.page, seen.slot, seen.last);
                    end
                end
            end
            // Register write transaction.
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_REPLACE_MODE) fifo_gets = cfg_data[0];
                else store_pages = cfg_data;
            end
            // Command transaction.
            if (s_tvalid && s_tready)
                predict_directory_step(s_tdata[2:0], s_tdata[34:3], s_tdata[35],
                                       s_tdata[39:36]);
        end
        fail_count <= fails;
        open_count <= expected_actions.size();
    end

endmodule

/* tb/tb_page_cache_lru_fifo_directory.sv */
// Testbench top for the page cache directory: clock, reset, stimulus and verdict.
module tb_page_cache_lru_fifo_directory
    import pcd_pkg::*;
();

    localparam int CLOCK_LIMIT  = 1_000_000;
    localparam int SETTLE_DELAY = 40;
    localparam int PHASE_ITEMS  = 94;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 7;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [30:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    int          fail_count;
    int          open_count;
    int          cycle_count = 0;

    // Stimulus-side controls read by the result receiver.
    logic        quiet       = 1'b0;
    logic        stall_flip  = 1'b0;
    logic        stall_seen  = 1'b0;
    int          hold_left   = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    page_cache_lru_fifo_directory uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    pcd_action_checker action_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLOCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (stall_flip != stall_seen) begin
            stall_seen = stall_flip;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offer one command transaction and wait until it is taken.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] page,
                                input logic full, input logic [3:0] ok);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ok, full, page, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering until every expected result is in, then let the block finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (open_count != 0);
        repeat (SETTLE_DELAY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [30:0]      phase_pages [5];
        logic             phase_fifo  [5];
        logic [CMD_W-1:0] cmd;
        logic [TAG_W-1:0] page;
        logic [3:0]       ok;
        int               pick;
        phase_pages = '{31'd40, 31'd40, 31'h7FFF_FFFF, 31'd0, 31'd60};
        phase_fifo = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(REG_REPLACE_MODE, 31'd0);
        write_reg(REG_BACKING_COUNT, 31'd40);

        // Directed part: bypasses, fetch failure, readahead bounds, hits, flush, unknown codes.
        send_command(CMD_READ, 32'd0, 1'b0, 4'hF);
        send_command(CMD_WRITE, 32'hFFFF_FFFF, 1'b0, 4'hF);
        send_command(CMD_GET, 32'h8000_0000, 1'b1, 4'hF);
        send_command(CMD_TOUCH, 32'd0, 1'b0, 4'h0);
        send_command(CMD_READ, 32'd5, 1'b0, 4'h0);
        send_command(CMD_READ, 32'd5, 1'b0, 4'hF);
        send_command(CMD_READ, 32'd38, 1'b0, 4'hF);
        send_command(CMD_WRITE, 32'd6, 1'b1, 4'hF);
        send_command(CMD_WRITE, 32'd20, 1'b1, 4'hF);
        send_command(CMD_WRITE, 32'd21, 1'b0, 4'h1);
        send_command(CMD_GET, 32'd7, 1'b0, 4'hF);
        send_command(CMD_TOUCH, 32'd8, 1'b0, 4'hF);
        send_command(CMD_READ, 32'h7FFF_FFFF, 1'b0, 4'hB);
        send_command(CMD_READ, 32'd9, 1'b0, 4'h5);
        send_command(CMD_FLUSH, 32'd9, 1'b0, 4'hF);
        send_command(CMD_FLUSH, 32'd1, 1'b0, 4'hF);
        send_command(3'd5, 32'd3, 1'b0, 4'hF);
        send_command(3'd7, 32'hA5A5_A5A5, 1'b1, 4'h0);
        send_command(3'd6, 32'h5A5A_5A5A, 1'b1, 4'hF);
        send_command(CMD_TOUCH, 32'h7FFF_FFFF, 1'b0, 4'hF);

        // Random part over several register settings.
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_reg(REG_REPLACE_MODE, {30'd0, phase_fifo[ph]});
            write_reg(REG_BACKING_COUNT, phase_pages[ph]);
            quiet <= (ph == 2);
            if (ph == 1) stall_flip <= ~stall_flip;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 32) cmd = CMD_READ;
                else if (pick < 56) cmd = CMD_WRITE;
                else if (pick < 72) cmd = CMD_GET;
                else if (pick < 94) cmd = CMD_TOUCH;
                else if (pick < 96) cmd = CMD_FLUSH;
                else cmd = 3'($urandom_range(5, 7));
                // Mostly a small page pool so that hits, evictions and write-backs occur.
                pick = $urandom_range(0, 99);
                if (pick < 80) page = $urandom_range(1, 50);
                else if (pick < 88) page = -$urandom_range(0, 3);
                else if (pick < 94) page = $urandom();
                else page = 32'h7FFF_FFF0 + $urandom_range(0, 15);
                ok = {3'($urandom_range(0, 7)), 1'($urandom_range(0, 99) < 85)};
                send_command(cmd, page, 1'($urandom_range(0, 1)), ok);
            end
        end

        settle();
        quiet <= 1'b0;
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* page_cache_lru_fifo_directory.f */
design/pcd_pkg.sv
design/pcd_cell.sv
design/pcd_ctrl.sv
design/page_cache_lru_fifo_directory.sv
tb/pcd_action_checker.sv
tb/tb_page_cache_lru_fifo_directory.sv
